// File: hw/rtl/gpd_pkg.sv
`timescale 1ns / 1ps

package gpd_pkg;

    localparam int WORD_BITS          = 16;
    localparam int CNT_W              = 21;
    localparam int DIST_W             = 19;
    localparam int DIST_MAG           = 2 ** (DIST_W - 1);
    localparam int MAX_MARKERS_DEF    = 1048576;
    localparam int FRACTION_BITS_DEF  = 16;

    localparam int NCLS               = 5;
    localparam int CLS_HH             = 0;
    localparam int CLS_IBS0           = 1;
    localparam int CLS_HOM            = 2;
    localparam int CLS_HET1           = 3;
    localparam int CLS_HET2           = 4;

    localparam int S_TDATA_W          = ((5 * WORD_BITS + 7) / 8) * 8;
    localparam int M_PAYLOAD_W        = 6 * CNT_W + DIST_W;
    localparam int M_TDATA_W          = ((M_PAYLOAD_W + 7) / 8) * 8;

    typedef struct packed {
        logic het2;
        logic het1;
        logic hom;
        logic ibs0;
        logic hethet;
    } t_cls;

    typedef enum logic [2:0] {
        S_ACC,
        S_FLUSH,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// File: hw/rtl/genotype_pair_distance_top.sv
// Flow: after a last word transfer the FSM steps through S_FLUSH, S_PREP, S_DIV and S_DONE;
//   S_DIV is skipped when no marker is genotyped in both; S_DONE waits for a free output.
// Throughput: one word per cycle while accumulating; after a last word the input stalls
//   until S_DONE loads the result, held up by the restoring divider (one quotient bit a cycle).
// Reset: synchronous active-low i_rst_n clears the counts, the control FSM and the
//   output valid.
`timescale 1ns / 1ps

module genotype_pair_distance_top
    import gpd_pkg::*;
#(
    parameter int MAX_MARKERS   = MAX_MARKERS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // first_plane_a, second_plane_a, first_plane_b, second_plane_b, marker_mask
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hethet_count, opposite_hom_count, same_hom_count, het_first_count,
    // het_second_count, nonmissing_count, distance, zero fill
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // no_markers
    output logic                  m_axis_tuser
);

    localparam int AW    = $clog2(MAX_MARKERS + 1);
    localparam int NUM_W = AW + 3;
    localparam int SW    = AW + 4;
    localparam int DVD_W = NUM_W + FRACTION_BITS;
    localparam int QW    = (DVD_W > DIST_W) ? DVD_W : DIST_W;

    t_state                   r_state;
    t_state                   n_state;
    logic                     in_xfer;
    t_cls [WORD_BITS-1:0]     cls;
    logic [NCLS-1:0][AW-1:0]  acc;
    logic                     div_start;
    logic                     div_done;
    logic [DVD_W-1:0]         quo;
    logic [QW-1:0]            quo_w;
    logic                     load;

    logic signed [SW-1:0]     s_hh, s_ib0, s_hom, s_h1, s_h2;
    logic signed [SW-1:0]     nm_s, num_s;
    logic [AW-1:0]            nm;
    logic [NUM_W-1:0]         num;
    logic [AW-1:0]            r_nm;
    logic [DIST_W-1:0]        mag;
    logic [DIST_W-1:0]        neg_dist;

    logic                     r_out_vld;
    logic [M_TDATA_W-1:0]     r_out_data;
    logic                     r_out_none;

    assign s_axis_tready = (r_state == S_ACC);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    for (genvar g = 0; g < WORD_BITS; g++) begin : g_lane
        gpd_lane u_lane (
            .i_first_a  (s_axis_tdata[g]),
            .i_second_a (s_axis_tdata[WORD_BITS + g]),
            .i_first_b  (s_axis_tdata[2 * WORD_BITS + g]),
            .i_second_b (s_axis_tdata[3 * WORD_BITS + g]),
            .i_mask     (s_axis_tdata[4 * WORD_BITS + g]),
            .o_cls      (cls[g])
        );
    end

    gpd_merge #(
        .MAX_MARKERS (MAX_MARKERS),
        .AW          (AW)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (in_xfer),
        .i_cls   (cls),
        .i_clr   (load),
        .o_acc   (acc)
    );

    assign s_hh  = $signed({4'b0, acc[CLS_HH]});
    assign s_ib0 = $signed({4'b0, acc[CLS_IBS0]});
    assign s_hom = $signed({4'b0, acc[CLS_HOM]});
    assign s_h1  = $signed({4'b0, acc[CLS_HET1]});
    assign s_h2  = $signed({4'b0, acc[CLS_HET2]});

    assign nm_s  = s_hom + s_ib0 + s_h1 + s_h2 - s_hh;
    assign num_s = s_h1 + s_h2 - (s_hh <<< 1) + (s_ib0 <<< 2);

    always_comb begin
        if (nm_s < 0) begin
            nm = '0;
        end else if (nm_s > SW'(MAX_MARKERS)) begin
            nm = AW'(MAX_MARKERS);
        end else begin
            nm = nm_s[AW-1:0];
        end
        num = (num_s < 0) ? '0 : num_s[NUM_W-1:0];
    end

    gpd_div #(
        .AW            (AW),
        .NUM_W         (NUM_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (num),
        .i_divisor  (nm),
        .o_done     (div_done),
        .o_quo      (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        load      = 1'b0;
        unique case (r_state)
            S_ACC: begin
                if (in_xfer && s_axis_tlast) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_PREP;
            end
            S_PREP: begin
                if (nm == '0) begin
                    n_state = S_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    load    = 1'b1;
                    n_state = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP) begin
            r_nm <= nm;
        end
    end

    assign quo_w    = QW'(quo);
    assign mag      = (quo_w > QW'(DIST_MAG)) ? DIST_W'(DIST_MAG) : quo_w[DIST_W-1:0];
    assign neg_dist = (r_nm == '0) ? '0 : DIST_W'(-mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= M_TDATA_W'({neg_dist,
                                      CNT_W'(r_nm),
                                      CNT_W'(acc[CLS_HET2]),
                                      CNT_W'(acc[CLS_HET1]),
                                      CNT_W'(acc[CLS_HOM]),
                                      CNT_W'(acc[CLS_IBS0]),
                                      CNT_W'(acc[CLS_HH])});
            r_out_none <= (r_nm == '0);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_none;

endmodule

// File: hw/rtl/gpd_lane.sv
`timescale 1ns / 1ps

module gpd_lane
    import gpd_pkg::*;
(
    input  logic i_first_a,
    input  logic i_second_a,
    input  logic i_first_b,
    input  logic i_second_b,
    input  logic i_mask,
    output t_cls o_cls
);

    logic a0, a1, b0, b1;

    assign a0 = i_first_a  & i_mask;
    assign a1 = i_second_a & i_mask;
    assign b0 = i_first_b  & i_mask;
    assign b1 = i_second_b & i_mask;

    assign o_cls.hethet = ~a0 & a1 & ~b0 & b1;
    assign o_cls.ibs0   = a0 & b0 & (a1 ^ b1);
    assign o_cls.hom    = a0 & b0 & ~(a1 ^ b1);
    assign o_cls.het1   = (b0 | b1) & ~a0 & a1;
    assign o_cls.het2   = (a0 | a1) & ~b0 & b1;

endmodule

// File: hw/rtl/gpd_merge.sv
`timescale 1ns / 1ps

module gpd_merge
    import gpd_pkg::*;
#(
    parameter int MAX_MARKERS = MAX_MARKERS_DEF,
    parameter int AW          = $clog2(MAX_MARKERS_DEF + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    input  t_cls [WORD_BITS-1:0]           i_cls,
    input  logic                           i_clr,
    output logic [NCLS-1:0][AW-1:0]        o_acc
);

    localparam int PC_W = $clog2(WORD_BITS + 1);

    logic                     r_vld;
    t_cls [WORD_BITS-1:0]     r_cls;
    logic [NCLS-1:0][AW-1:0]  r_acc;
    logic [NCLS-1:0][AW-1:0]  n_acc;
    logic [NCLS-1:0][PC_W-1:0] pc;
    logic [NCLS-1:0][AW:0]    sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_cls <= i_cls;
        end
    end

    always_comb begin
        pc = '0;
        for (int k = 0; k < NCLS; k++) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                pc[k] = pc[k] + PC_W'(r_cls[i][k]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NCLS; k++) begin
            sum[k] = {1'b0, r_acc[k]} + (AW + 1)'(pc[k]);
            if (sum[k] > (AW + 1)'(MAX_MARKERS)) begin
                n_acc[k] = AW'(MAX_MARKERS);
            end else begin
                n_acc[k] = sum[k][AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_acc <= '0;
        end else if (r_vld) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// File: hw/rtl/gpd_div.sv
`timescale 1ns / 1ps

module gpd_div
    import gpd_pkg::*;
#(
    parameter int AW            = $clog2(MAX_MARKERS_DEF + 1),
    parameter int NUM_W         = $clog2(MAX_MARKERS_DEF + 1) + 3,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [NUM_W-1:0]                  i_dividend,
    input  logic [AW-1:0]                     i_divisor,
    output logic                              o_done,
    output logic [NUM_W+FRACTION_BITS-1:0]    o_quo
);

    localparam int DVD_W = NUM_W + FRACTION_BITS;
    localparam int IT_W  = $clog2(DVD_W);

    logic             r_busy;
    logic [IT_W-1:0]  r_cnt;
    logic [AW-1:0]    r_dvs;
    logic [AW-1:0]    r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [AW:0]      rem_sh;
    logic             ge;
    logic [AW:0]      rem_sub;

    assign rem_sh  = {r_rem, r_quo[DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign o_done  = r_busy && (r_cnt == IT_W'(DVD_W - 1));
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_busy <= !o_done;
            r_cnt  <= r_cnt + IT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= {i_dividend, {FRACTION_BITS{1'b0}}};
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[AW-1:0] : rem_sh[AW-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

endmodule

// File: dv/genotype_pair_distance_top_tb.sv
`timescale 1ns / 1ps

module genotype_pair_distance_top_tb;
    import gpd_pkg::*;

    localparam int TB_MAX_MARKERS = MAX_MARKERS_DEF;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int LONG_HOLD      = 300;
    localparam int WORDS_PER_PASS = 250;

    typedef struct packed {
        logic [WORD_BITS-1:0] first_a;
        logic [WORD_BITS-1:0] second_a;
        logic [WORD_BITS-1:0] first_b;
        logic [WORD_BITS-1:0] second_b;
        logic [WORD_BITS-1:0] mask;
        logic                 last_word;
    } t_pair_word;

    typedef struct packed {
        logic [CNT_W-1:0]         hethet;
        logic [CNT_W-1:0]         opposite_hom;
        logic [CNT_W-1:0]         same_hom;
        logic [CNT_W-1:0]         het_first;
        logic [CNT_W-1:0]         het_second;
        logic [CNT_W-1:0]         nonmissing;
        logic signed [DIST_W-1:0] distance;
        logic                     no_markers;
    } t_pair_distance;

    typedef struct packed {
        logic [WORD_BITS-1:0] first_a;
        logic [WORD_BITS-1:0] second_a;
        logic [WORD_BITS-1:0] first_b;
        logic [WORD_BITS-1:0] second_b;
        logic [WORD_BITS-1:0] mask;
        logic [7:0]           reps;
        logic                 last_word;
        logic                 typed;
        t_pair_distance       want;
    } t_word_row;

    localparam t_word_row WORD_TABLE [18] = '{
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 8'd1, 1'b1, 1'b1,
          '{0, 0, 0, 0, 0, 0, 0, 1}},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd1, 1'b1, 1'b1,
          '{0, 16, 0, 0, 0, 16, -262144, 0}},
        '{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1, 1'b1,
          '{0, 16, 0, 0, 0, 16, -262144, 0}},
        '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd1, 1'b1, 1'b1,
          '{0, 0, 16, 0, 0, 16, 0, 0}},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1, 1'b1,
          '{0, 0, 16, 0, 0, 16, 0, 0}},
        '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1, 1'b1,
          '{16, 0, 0, 16, 16, 16, 0, 0}},
        '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd1, 1'b1, 1'b1,
          '{0, 0, 0, 16, 0, 16, -65536, 0}},
        '{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1, 1'b1,
          '{0, 0, 0, 0, 16, 16, -65536, 0}},
        '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1, 1'b1,
          '{0, 0, 0, 0, 0, 0, 0, 1}},
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 8'd1, 1'b1, 1'b1,
          '{0, 0, 0, 0, 0, 0, 0, 1}},
        '{16'h5A5A, 16'h33CC, 16'h0FF0, 16'hC3A5, 16'hFFFF, 8'd1, 1'b1, 1'b0, '0},
        '{16'h1234, 16'hABCD, 16'hF0F0, 16'h0F0F, 16'hFFFF, 8'd2, 1'b0, 1'b0, '0},
        '{16'h8001, 16'h7FFE, 16'hFFFF, 16'h0001, 16'h00FF, 8'd1, 1'b1, 1'b0, '0},
        '{16'h0001, 16'h0000, 16'h0001, 16'h0001, 16'h0001, 8'd1, 1'b1, 1'b1,
          '{0, 1, 0, 0, 0, 1, -262144, 0}},
        '{16'h0000, 16'h0001, 16'h0001, 16'h0000, 16'h0001, 8'd1, 1'b1, 1'b1,
          '{0, 0, 0, 1, 0, 1, -65536, 0}},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd5, 1'b1, 1'b1,
          '{0, 80, 0, 0, 0, 80, -262144, 0}},
        '{16'h00FF, 16'hFF0F, 16'hF0FF, 16'h0F00, 16'hFFFF, 8'd9, 1'b1, 1'b0, '0},
        '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 8'd1, 1'b1, 1'b1,
          '{0, 0, 0, 1, 0, 1, -65536, 0}}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // first_plane_a, second_plane_a, first_plane_b, second_plane_b, marker_mask
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // hethet_count, opposite_hom_count, same_hom_count, het_first_count,
    // het_second_count, nonmissing_count, distance, zero fill
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // no_markers
    logic                 m_axis_tuser;

    t_pair_distance pending_results [$];
    int             class_tally [NCLS] = '{default: 0};
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_idle_pct = 0;
    int unsigned    hold_requests = 0;
    int unsigned    holds_served = 0;
    int unsigned    hold_left = 0;
    int unsigned    mismatch_count = 0;
    int unsigned    cycle_count = 0;

    genotype_pair_distance_top #(
        .MAX_MARKERS   (TB_MAX_MARKERS),
        .FRACTION_BITS (FRACTION_BITS_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("genotype_pair_distance_top_tb: errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic bit tally_word(input t_pair_word w, output t_pair_distance r);
        logic [WORD_BITS-1:0] a0, a1, b0, b1;
        logic [WORD_BITS-1:0] hit [NCLS];
        longint               nm, num, q;
        a0 = w.first_a & w.mask;
        a1 = w.second_a & w.mask;
        b0 = w.first_b & w.mask;
        b1 = w.second_b & w.mask;
        hit[CLS_HH]   = ~a0 & a1 & ~b0 & b1;
        hit[CLS_IBS0] = a0 & b0 & (a1 ^ b1);
        hit[CLS_HOM]  = a0 & b0 & ~(a1 ^ b1);
        hit[CLS_HET1] = (b0 | b1) & ~a0 & a1;
        hit[CLS_HET2] = (a0 | a1) & ~b0 & b1;
        for (int k = 0; k < NCLS; k++) begin
            class_tally[k] = class_tally[k] + $countones(hit[k]);
            if (class_tally[k] > TB_MAX_MARKERS)
                class_tally[k] = TB_MAX_MARKERS;
        end
        r = '0;
        if (!w.last_word)
            return 1'b0;
        nm = longint'(class_tally[CLS_HOM]) + class_tally[CLS_IBS0]
           + class_tally[CLS_HET1] + class_tally[CLS_HET2] - class_tally[CLS_HH];
        if (nm < 0)
            nm = 0;
        if (nm > TB_MAX_MARKERS)
            nm = TB_MAX_MARKERS;
        if (nm == 0) begin
            r.no_markers = 1'b1;
        end else begin
            num = longint'(class_tally[CLS_HET1]) + class_tally[CLS_HET2]
                - 2 * class_tally[CLS_HH] + 4 * class_tally[CLS_IBS0];
            if (num < 0)
                num = 0;
            q = (num << FRACTION_BITS_DEF) / nm;
            if (q > DIST_MAG)
                q = DIST_MAG;
            r.distance = DIST_W'(-q);
        end
        r.hethet       = CNT_W'(class_tally[CLS_HH]);
        r.opposite_hom = CNT_W'(class_tally[CLS_IBS0]);
        r.same_hom     = CNT_W'(class_tally[CLS_HOM]);
        r.het_first    = CNT_W'(class_tally[CLS_HET1]);
        r.het_second   = CNT_W'(class_tally[CLS_HET2]);
        r.nonmissing   = CNT_W'(nm);
        for (int k = 0; k < NCLS; k++)
            class_tally[k] = 0;
        return 1'b1;
    endfunction

    task automatic send_word(input t_pair_word w, input bit typed, input t_pair_distance want);
        t_pair_distance r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.mask, w.second_b, w.first_b, w.second_a, w.first_a};
        s_axis_tlast  <= w.last_word;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (tally_word(w, r)) begin
            if (typed)
                r = want;
            pending_results.push_back(r);
        end
    endtask

    function automatic t_pair_word random_word(input bit is_last);
        t_pair_word  w;
        int unsigned pick;
        w.first_a  = WORD_BITS'($urandom);
        w.second_a = WORD_BITS'($urandom);
        w.first_b  = WORD_BITS'($urandom);
        w.second_b = WORD_BITS'($urandom);
        pick = $urandom_range(99);
        if (pick < 60)
            w.mask = '1;
        else if (pick < 68)
            w.mask = '0;
        else
            w.mask = WORD_BITS'($urandom);
        pick = $urandom_range(9);
        if (pick == 0) begin
            w.first_a  = w.first_a & WORD_BITS'($urandom);
            w.second_a = w.second_a & WORD_BITS'($urandom);
        end else if (pick == 1) begin
            w.first_b  = w.first_b & WORD_BITS'($urandom);
            w.second_b = w.second_b & WORD_BITS'($urandom);
        end else if (pick == 2) begin
            w.first_b  = w.first_a;
            w.second_b = w.second_a;
        end
        w.last_word = is_last;
        return w;
    endfunction

    task automatic check_result();
        t_pair_distance got, want;
        got.hethet       = m_axis_tdata[0 * CNT_W +: CNT_W];
        got.opposite_hom = m_axis_tdata[1 * CNT_W +: CNT_W];
        got.same_hom     = m_axis_tdata[2 * CNT_W +: CNT_W];
        got.het_first    = m_axis_tdata[3 * CNT_W +: CNT_W];
        got.het_second   = m_axis_tdata[4 * CNT_W +: CNT_W];
        got.nonmissing   = m_axis_tdata[5 * CNT_W +: CNT_W];
        got.distance     = m_axis_tdata[6 * CNT_W +: DIST_W];
        got.no_markers   = m_axis_tuser;
        if (pending_results.size() == 0) begin
            report_mismatch("result with none pending", got.nonmissing, 0);
            return;
        end
        want = pending_results.pop_front();
        if (got.hethet != want.hethet)
            report_mismatch("hethet_count", got.hethet, want.hethet);
        if (got.opposite_hom != want.opposite_hom)
            report_mismatch("opposite_hom_count", got.opposite_hom, want.opposite_hom);
        if (got.same_hom != want.same_hom)
            report_mismatch("same_hom_count", got.same_hom, want.same_hom);
        if (got.het_first != want.het_first)
            report_mismatch("het_first_count", got.het_first, want.het_first);
        if (got.het_second != want.het_second)
            report_mismatch("het_second_count", got.het_second, want.het_second);
        if (got.nonmissing != want.nonmissing)
            report_mismatch("nonmissing_count", got.nonmissing, want.nonmissing);
        if (got.distance != want.distance)
            report_mismatch("distance", got.distance, want.distance);
        if (got.no_markers != want.no_markers)
            report_mismatch("no_markers", got.no_markers, want.no_markers);
    endtask

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            check_result();
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        t_pair_word  w;
        int unsigned sent, len;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (WORD_TABLE[r]) begin
            for (int k = 0; k < WORD_TABLE[r].reps; k++) begin
                w.first_a   = WORD_TABLE[r].first_a;
                w.second_a  = WORD_TABLE[r].second_a;
                w.first_b   = WORD_TABLE[r].first_b;
                w.second_b  = WORD_TABLE[r].second_b;
                w.mask      = WORD_TABLE[r].mask;
                w.last_word = (k == WORD_TABLE[r].reps - 1) ? WORD_TABLE[r].last_word : 1'b0;
                send_word(w, WORD_TABLE[r].typed, WORD_TABLE[r].want);
            end
        end

        for (int pass = 0; pass < 3; pass++) begin
            case (pass)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 53;
                    hold_requests = hold_requests + 1;
                end
                1: begin
                    send_idle_pct = 53;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < WORDS_PER_PASS) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(14, 6) : $urandom_range(4, 1);
                for (int k = 0; k < len; k++) begin
                    send_word(random_word(k == len - 1), 1'b0, '0);
                    sent++;
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("genotype_pair_distance_top_tb: clean");
        else
            $display("genotype_pair_distance_top_tb: errors");
        $finish;
    end

endmodule
